[src/mqtt_sn_stream_deframer_macros.svh]
// ----------------------------------------------------------------------------
// MQTT-SN stream deframer assertion macros
// Concurrent assertion wrappers shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef MQTT_SN_STREAM_DEFRAMER_MACROS_SVH
`define MQTT_SN_STREAM_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge outside reset.
`define MQSN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define MQSN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MQSN_ASSERT(lbl, prop, msg)
`define MQSN_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[src/mqsn_dfr_pkg.sv]
// ----------------------------------------------------------------------------
// MQTT-SN stream deframer package
// Types and constants shared by the deframer RTL.
// ----------------------------------------------------------------------------
package mqsn_dfr_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 3;

  localparam logic [7:0] LONG_FORM_PREFIX = 8'h01;

  // Total of a message that carries only a length field and a type octet.
  localparam logic [16:0] MIN_TOTAL_SHORT = 17'd2;
  localparam logic [16:0] MIN_TOTAL_LONG  = 17'd4;

  typedef enum logic [4:0] {
    PH_FIRST   = 5'b00001,
    PH_LEN_HI  = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_TYPE    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_LEN     = 2'd0,
    KIND_TYPE    = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] payload_index;
    logic [15:0] message_length;
    logic [7:0]  message_type;
    logic [7:0]  byte_out;
    kind_t       byte_kind;
    logic        end_of_message;
    logic        length_error;
  } result_t;

endpackage

[src/mqtt_sn_stream_deframer.sv]
// ----------------------------------------------------------------------------
// MQTT-SN stream deframer
// Tags each octet of an MQTT-SN stream with its role in the current message.
// ----------------------------------------------------------------------------
// The block takes one octet per item and gives one result item for each,
// in order. It accepts one item in every cycle while the skid register is
// empty: the framing state is a small register updated by a single pass of
// logic, and the results leave through an output register backed by a
// one-entry skid register, so the input takes one more octet while the
// output is stalled. out_tdata carries the octet, the message type, the total
// length and the payload index; out_tuser carries the octet's kind and the
// length error flag; out_tlast marks the octet that completes a message.
`include "mqtt_sn_stream_deframer_macros.svh"

module mqtt_sn_stream_deframer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mqsn_dfr_pkg::IN_TDATA_W-1:0]  in_tdata,  // [7:0] data_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [7:0] byte_out, [15:8] message_type, [31:16] message_length,
  // [47:32] payload_index
  output logic [mqsn_dfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [mqsn_dfr_pkg::OUT_TUSER_W-1:0] out_tuser, // [1:0] byte_kind, [2] length_error
  output logic                                 out_tlast  // end_of_message
);
  import mqsn_dfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] total_r, total_nxt;
  logic        long_r, long_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] seen_r, seen_nxt;

  logic        out_valid_r, skid_valid_r;
  result_t     out_r, skid_r, res;

  logic        in_fire, out_free;
  logic [7:0]  b;
  logic [16:0] fs_plus1;
  logic [15:0] seen_inc;
  logic [16:0] seen_end;

  assign b         = in_tdata;
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign fs_plus1 = long_r ? MIN_TOTAL_LONG : MIN_TOTAL_SHORT;
  assign seen_inc = seen_r + 16'd1;
  assign seen_end = {1'b0, seen_inc} + fs_plus1;

  always_comb begin
    phase_nxt = phase_r;
    total_nxt = total_r;
    long_nxt  = long_r;
    type_nxt  = type_r;
    seen_nxt  = seen_r;

    res                = '0;
    res.byte_out       = b;
    res.byte_kind      = KIND_LEN;

    unique case (phase_r)
      PH_LEN_HI: begin
        total_nxt = {b, 8'h00};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        total_nxt          = {total_r[15:8], b};
        res.message_length = {total_r[15:8], b};
        if ({1'b0, total_r[15:8], b} < MIN_TOTAL_LONG) begin
          res.length_error = 1'b1;
          phase_nxt        = PH_FIRST;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        res.byte_kind      = KIND_TYPE;
        type_nxt           = b;
        res.message_type   = b;
        res.message_length = total_r;
        seen_nxt           = '0;
        if ({1'b0, total_r} == fs_plus1) begin
          res.end_of_message = 1'b1;
          phase_nxt          = PH_FIRST;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.byte_kind      = KIND_PAYLOAD;
        res.message_type   = type_r;
        res.message_length = total_r;
        res.payload_index  = seen_r;
        seen_nxt           = seen_inc;
        if (seen_end >= {1'b0, total_r}) begin
          res.end_of_message = 1'b1;
          phase_nxt          = PH_FIRST;
        end
      end
      default: begin
        type_nxt = '0;
        seen_nxt = '0;
        if (b == LONG_FORM_PREFIX) begin
          long_nxt  = 1'b1;
          total_nxt = '0;
          phase_nxt = PH_LEN_HI;
        end else begin
          long_nxt           = 1'b0;
          total_nxt          = {8'h00, b};
          res.message_length = {8'h00, b};
          if ({9'h000, b} < MIN_TOTAL_SHORT) begin
            res.length_error = 1'b1;
            phase_nxt        = PH_FIRST;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      total_r <= '0;
      long_r  <= 1'b0;
      type_r  <= '0;
      seen_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      total_r <= total_nxt;
      long_r  <= long_nxt;
      type_r  <= type_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_fire;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res;
      end
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.payload_index, out_r.message_length,
                       out_r.message_type, out_r.byte_out};
  assign out_tuser  = {out_r.length_error, out_r.byte_kind};
  assign out_tlast  = out_r.end_of_message;

  `MQSN_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_valid_r || !rst_n,
                      "skid entry held while output register is empty")
  `MQSN_ASSERT(a_err_not_last, (out_valid_r && out_r.length_error) |-> !out_r.end_of_message,
               "length error result marked as end of message")
  `MQSN_ASSERT(a_index_in_msg,
               (out_valid_r && out_r.byte_kind == KIND_PAYLOAD) |->
               (out_r.payload_index < out_r.message_length),
               "payload index beyond message length")
  `MQSN_ASSERT(a_payload_room,
               (phase_r == PH_PAYLOAD) |-> (({1'b0, seen_r} + fs_plus1) < {1'b0, total_r}),
               "payload phase with no octets left in the message")
  `MQSN_ASSERT(a_skid_only_on_stall, $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready),
               "skid register filled without an output stall")

endmodule
